// ----- hw/rtl/lfr_pkg.sv -----
// shared constants, reset table and state encoding of the lagged-fibonacci generator
`default_nettype none
package lfr_pkg;

    localparam int TABLE_DEPTH = 55;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WORD_W      = 32;
    localparam int VALUE_W     = 24;
    localparam int VALUE_SHIFT = 8;
    localparam int USEC_W      = 20;
    localparam int LAG_GAP     = 20;
    localparam int RECIP_SHIFT = 37;

    localparam logic [WORD_W-1:0] MUL_SEC   = 32'd999;
    localparam logic [WORD_W-1:0] MUL_USEC  = 32'd1001;
    localparam logic [WORD_W-1:0] MUL_TICK  = 32'd1003;
    localparam logic [WORD_W-1:0] MUL_PREV  = 32'd1001;
    localparam logic [WORD_W-1:0] MUL_SEED  = 32'd999;
    localparam logic [WORD_W-1:0] RECIP_MUL = 32'd2498890063;

    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    localparam logic [WORD_W-1:0] RESET_WORDS [TABLE_DEPTH] = '{
        32'o35340171546, 32'o10401501101, 32'o22364657325, 32'o24130436022, 32'o02167303062,
        32'o37570375137, 32'o37210607110, 32'o16272055420, 32'o23011770546, 32'o17143426366,
        32'o14753657433, 32'o21657231332, 32'o23553406142, 32'o04236526362, 32'o10365611275,
        32'o07117336710, 32'o11051276551, 32'o02362132524, 32'o01011540233, 32'o12162531646,
        32'o07056762337, 32'o06631245521, 32'o14164542224, 32'o32633236305, 32'o23342700176,
        32'o02433062234, 32'o15257225043, 32'o26762051606, 32'o00742573230, 32'o05366042132,
        32'o12126416411, 32'o00520471171, 32'o00725646277, 32'o20116577576, 32'o25765742604,
        32'o07633473735, 32'o15674255275, 32'o17555634041, 32'o06503154145, 32'o21576344247,
        32'o14577627653, 32'o02707523333, 32'o34146376720, 32'o30060227734, 32'o13765414060,
        32'o36072251540, 32'o07255221037, 32'o24364674123, 32'o06200353166, 32'o10126373326,
        32'o15664104320, 32'o16401041535, 32'o16215305520, 32'o33115351014, 32'o17411670323
    };

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_DRAW,
        ST_SEED_A,
        ST_SEED_B,
        ST_SEED_C,
        ST_RS_READ,
        ST_RS_ADD,
        ST_RS_MUL,
        ST_RS_MIX,
        ST_RS_MOD,
        ST_RS_REM
    } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lfr_channels.sv -----
// valid/ready channel interfaces for requests and random values
`default_nettype none
interface lfr_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] seconds;
    logic [19:0] microseconds;
    logic [31:0] ticks;

    modport source (output valid, output operation, output seconds, output microseconds,
                    output ticks, input ready);
    modport sink   (input valid, input operation, input seconds, input microseconds,
                    input ticks, output ready);
endinterface

interface lfr_rsp_if;
    logic        valid;
    logic        ready;
    logic [23:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lagged_fibonacci_random.sv -----
// additive lagged-fibonacci random generator with table memory and reseed sequencer
//
// The 55-word table lives in a synchronous memory with two read ports and one
// write port. After reset the block loads the constant table and holds req.ready
// low meanwhile. A draw beat reads the memory, then adds, writes back and
// registers the result; no new request is taken until it is done, and a draw
// waits while an earlier result is not taken. A reseed beat gives no result:
// ST_SEED_A to ST_SEED_C build the seed from seconds, microseconds and ticks
// by constant multiplications, each word then takes a read, add and write-back,
// each word after the first also the ST_RS_MUL and ST_RS_MIX steps for the seed
// recurrence, and ST_RS_MOD and ST_RS_REM derive the indices from word 0 modulo
// 55 by a reciprocal multiplication and one correcting subtraction. A finished
// random value waits in an output register while the next request is taken.
`default_nettype none
module lagged_fibonacci_random (
    input  wire        clk,
    input  wire        rst_n,
    lfr_req_if.sink    req,
    lfr_rsp_if.source  rsp
);
    import lfr_pkg::*;

    state_t state_reg, state_next;

    logic [WORD_W-1:0]   table_mem [TABLE_DEPTH];
    logic [WORD_W-1:0]   rda_reg, rdb_reg;
    logic                rd_en;
    logic [IDX_W-1:0]    raddr_a, raddr_b;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;

    logic [IDX_W-1:0]    first_reg, first_next;
    logic [IDX_W-1:0]    second_reg, second_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W:0]      quot_reg, quot_next;
    logic                out_valid_reg, out_valid_next;

    logic [WORD_W-1:0]   sec_reg, sec_next;
    logic [USEC_W-1:0]   usec_reg, usec_next;
    logic [WORD_W-1:0]   tck_reg, tck_next;
    logic [WORD_W-1:0]   seed_reg, seed_next;
    logic [WORD_W-1:0]   prev_reg, prev_next;
    logic [WORD_W-1:0]   mul_reg, mul_next;
    logic [WORD_W-1:0]   w0_reg, w0_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;

    logic                accept;
    logic                draw_fire;
    logic                last_word;
    logic [WORD_W-1:0]   draw_sum;
    logic [WORD_W-1:0]   word_sum;
    logic [2*WORD_W-1:0] recip_prod;
    logic [IDX_W:0]      rem_trial;
    logic [IDX_W-1:0]    rem_step;
    logic [IDX_W:0]      second_trial;

    assign req.ready        = (state_reg == ST_IDLE);
    assign accept           = req.valid && req.ready;
    assign draw_fire        = (state_reg == ST_DRAW) && (!out_valid_reg || rsp.ready);
    assign last_word        = (cnt_reg == IDX_W'(TABLE_DEPTH - 1));
    assign draw_sum         = rda_reg + rdb_reg;
    assign word_sum         = rda_reg + seed_reg;
    // quotient estimate is exact or one low, so the remainder is below 2*55
    assign recip_prod       = (2*WORD_W)'(w0_reg) * (2*WORD_W)'(RECIP_MUL);
    assign rem_trial        = w0_reg[IDX_W:0] - quot_reg * (IDX_W+1)'(TABLE_DEPTH);
    assign rem_step         = (rem_trial >= (IDX_W+1)'(TABLE_DEPTH))
                              ? IDX_W'(rem_trial - (IDX_W+1)'(TABLE_DEPTH))
                              : IDX_W'(rem_trial);
    assign second_trial     = {1'b0, rem_step} + (IDX_W+1)'(LAG_GAP);
    assign rsp.valid        = out_valid_reg;
    assign rsp.random_value = out_value_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (last_word)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = (req.operation == OP_DRAW) ? ST_DRAW : ST_SEED_A;
            end
            ST_DRAW:
            begin
                if (draw_fire)
                    state_next = ST_IDLE;
            end
            ST_SEED_A:  state_next = ST_SEED_B;
            ST_SEED_B:  state_next = ST_SEED_C;
            ST_SEED_C:  state_next = ST_RS_READ;
            ST_RS_READ: state_next = ST_RS_ADD;
            ST_RS_ADD:  state_next = last_word ? ST_RS_MOD : ST_RS_MUL;
            ST_RS_MUL:  state_next = ST_RS_MIX;
            ST_RS_MIX:  state_next = ST_RS_READ;
            ST_RS_MOD:  state_next = ST_RS_REM;
            ST_RS_REM:  state_next = ST_IDLE;
            default:    state_next = ST_FILL;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        rd_en          = 1'b0;
        raddr_a        = first_reg;
        raddr_b        = second_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = RESET_WORDS[cnt_reg];
        first_next     = first_reg;
        second_next    = second_reg;
        cnt_next       = cnt_reg;
        quot_next      = quot_reg;
        sec_next       = sec_reg;
        usec_next      = usec_reg;
        tck_next       = tck_reg;
        seed_next      = seed_reg;
        prev_next      = prev_reg;
        mul_next       = mul_reg;
        w0_next        = w0_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            ST_FILL:
            begin
                mem_we   = 1'b1;
                cnt_next = last_word ? '0 : cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_en     = 1'b1;
                    sec_next  = req.seconds;
                    usec_next = req.microseconds;
                    tck_next  = req.ticks;
                end
            end
            ST_DRAW:
            begin
                if (draw_fire)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = first_reg;
                    mem_wdata      = draw_sum;
                    out_value_next = draw_sum[VALUE_SHIFT +: VALUE_W];
                    out_valid_next = 1'b1;
                    first_next     = (first_reg == IDX_W'(TABLE_DEPTH - 1))
                                     ? '0 : first_reg + 1'b1;
                    second_next    = (second_reg == IDX_W'(TABLE_DEPTH - 1))
                                     ? '0 : second_reg + 1'b1;
                end
            end
            ST_SEED_A:
            begin
                seed_next = sec_reg * MUL_SEC;
                cnt_next  = '0;
            end
            ST_SEED_B:
            begin
                seed_next = seed_reg + {{(WORD_W-USEC_W){1'b0}}, usec_reg} * MUL_USEC;
            end
            ST_SEED_C:
            begin
                seed_next = seed_reg + tck_reg * MUL_TICK;
            end
            ST_RS_READ:
            begin
                rd_en   = 1'b1;
                raddr_a = cnt_reg;
            end
            ST_RS_ADD:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = word_sum;
                prev_next = word_sum;
                if (cnt_reg == '0)
                    w0_next = word_sum;
                if (last_word)
                    cnt_next = '0;
            end
            ST_RS_MUL:
            begin
                mul_next = prev_reg * MUL_PREV;
            end
            ST_RS_MIX:
            begin
                seed_next = mul_reg + seed_reg * MUL_SEED;
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_RS_MOD:
            begin
                quot_next = recip_prod[RECIP_SHIFT +: IDX_W+1];
            end
            ST_RS_REM:
            begin
                first_next  = rem_step;
                second_next = (second_trial >= (IDX_W+1)'(TABLE_DEPTH))
                              ? IDX_W'(second_trial - (IDX_W+1)'(TABLE_DEPTH))
                              : IDX_W'(second_trial);
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
        begin
            rda_reg <= table_mem[raddr_a];
            rdb_reg <= table_mem[raddr_b];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            first_reg     <= '0;
            second_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        quot_reg      <= quot_next;
        sec_reg       <= sec_next;
        usec_reg      <= usec_next;
        tck_reg       <= tck_next;
        seed_reg      <= seed_next;
        prev_reg      <= prev_next;
        mul_reg       <= mul_next;
        w0_reg        <= w0_next;
        out_value_reg <= out_value_next;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lfr_checker.sv -----
// port-level assertions for the lagged-fibonacci generator and their bind
`default_nettype none
module lfr_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        req_valid,
    input wire        req_ready,
    input wire        req_operation,
    input wire        rsp_valid,
    input wire        rsp_ready,
    input wire [23:0] rsp_random_value
);
    import lfr_pkg::*;

    // result held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_random_value))
        else $error("result changed while stalled");

    // reseed gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_operation == OP_RESEED)
        && (!rsp_valid || rsp_ready) |=> !rsp_valid)
        else $error("reseed produced a result");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind lagged_fibonacci_random lfr_checker u_lfr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_operation    (req.operation),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_random_value (rsp.random_value)
);
`default_nettype wire

// ----- tb/lagged_fibonacci_random_tb.sv -----
// testbench for the lagged-fibonacci generator: draws and reseeds checked against a table predictor
module lagged_fibonacci_random_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfr_pkg::*;

    localparam int N_RANDOM   = 730;
    localparam int WAIT_MAX   = 16;
    localparam int DRAIN      = 300;
    localparam int STALL_MAX  = 2000;
    localparam int PRINT_MAX  = 40;

    localparam bit [31:0] START_WORDS [55] = '{
        32'o35340171546, 32'o10401501101, 32'o22364657325, 32'o24130436022, 32'o02167303062,
        32'o37570375137, 32'o37210607110, 32'o16272055420, 32'o23011770546, 32'o17143426366,
        32'o14753657433, 32'o21657231332, 32'o23553406142, 32'o04236526362, 32'o10365611275,
        32'o07117336710, 32'o11051276551, 32'o02362132524, 32'o01011540233, 32'o12162531646,
        32'o07056762337, 32'o06631245521, 32'o14164542224, 32'o32633236305, 32'o23342700176,
        32'o02433062234, 32'o15257225043, 32'o26762051606, 32'o00742573230, 32'o05366042132,
        32'o12126416411, 32'o00520471171, 32'o00725646277, 32'o20116577576, 32'o25765742604,
        32'o07633473735, 32'o15674255275, 32'o17555634041, 32'o06503154145, 32'o21576344247,
        32'o14577627653, 32'o02707523333, 32'o34146376720, 32'o30060227734, 32'o13765414060,
        32'o36072251540, 32'o07255221037, 32'o24364674123, 32'o06200353166, 32'o10126373326,
        32'o15664104320, 32'o16401041535, 32'o16215305520, 32'o33115351014, 32'o17411670323
    };

    class lfr_sequence_tracker;
        bit [31:0] words [55];
        bit [5:0]  first_idx;
        bit [5:0]  second_idx;
        bit [23:0] expected_values [$];
        int        errors;
        int        draws;
        int        reseeds;
        int        values_seen;

        function new();
            foreach (words[i])
                words[i] = START_WORDS[i];
            first_idx  = '0;
            second_idx = '0;
            errors     = 0;
            draws      = 0;
            reseeds    = 0;
            values_seen = 0;
        endfunction

        function void predict_beat(bit op, bit [31:0] sec, bit [19:0] usec, bit [31:0] tck);
            bit [31:0] seed;
            bit [31:0] sum;
            bit [31:0] usec_w;
            if (op == OP_RESEED)
            begin
                usec_w = {12'd0, usec};
                seed = sec * 32'd999 + usec_w * 32'd1001 + tck * 32'd1003;
                words[0] = words[0] + seed;
                for (int w = 1; w < 55; w++)
                begin
                    seed = words[w - 1] * 32'd1001 + seed * 32'd999;
                    words[w] = words[w] + seed;
                end
                first_idx  = 6'(words[0] % 32'd55);
                second_idx = 6'((32'(first_idx) + 32'd20) % 32'd55);
                reseeds++;
            end
            else
            begin
                sum = words[first_idx] + words[second_idx];
                words[first_idx] = sum;
                first_idx  = (first_idx == 6'd54) ? 6'd0 : first_idx + 6'd1;
                second_idx = (second_idx == 6'd54) ? 6'd0 : second_idx + 6'd1;
                expected_values.push_back(sum[31:8]);
                draws++;
            end
        endfunction

        task report_mismatch(string what);
            if (errors < PRINT_MAX)
                $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_value(bit [23:0] got);
            bit [23:0] want;
            values_seen++;
            if (expected_values.size() == 0)
                report_mismatch($sformatf("random_value %06h with nothing pending", got));
            else
            begin
                want = expected_values.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("random_value %06h, want %06h", got, want));
            end
        endtask

        task check_drained();
            if (expected_values.size() != 0)
                report_mismatch($sformatf("%0d random values never arrived",
                                          expected_values.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;

    lfr_req_if req_ch();
    lfr_rsp_if rsp_ch();

    lagged_fibonacci_random dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    lfr_sequence_tracker tracker = new();
    bit req_steady;
    bit rsp_steady;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_wait(bit steady);
        return steady ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    task automatic send_request(input bit op, input bit [31:0] sec, input bit [19:0] usec,
                                input bit [31:0] tck);
        int gap;
        gap = pick_wait(req_steady);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.seconds      <= sec;
        req_ch.microseconds <= usec;
        req_ch.ticks        <= tck;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        tracker.predict_beat(op, sec, usec, tck);
    endtask

    task automatic send_draw();
        send_request(OP_DRAW, $urandom(), 20'($urandom()), $urandom());
    endtask

    task automatic send_random_reseed();
        bit [31:0] sec;
        bit [19:0] usec;
        bit [31:0] tck;
        case ($urandom_range(0, 5))
            0: sec = 32'hFFFF_FFFF;
            1: sec = 32'd0;
            default: sec = $urandom();
        endcase
        case ($urandom_range(0, 5))
            0: usec = 20'hF_FFFF;
            1: usec = 20'd999_999;
            2: usec = 20'($urandom_range(0, 999_999));
            default: usec = 20'($urandom());
        endcase
        case ($urandom_range(0, 5))
            0: tck = 32'hFFFF_FFFF;
            1: tck = 32'd0;
            default: tck = $urandom();
        endcase
        send_request(OP_RESEED, sec, usec, tck);
    endtask

    // response side
    initial
    begin
        int stall;
        int beats;
        beats = 0;
        rsp_steady = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (beats % 40 == 0)
                rsp_steady = ($urandom_range(0, 3) == 0);
            stall = pick_wait(rsp_steady);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (rsp_ch.valid !== 1'b1)
                @(posedge clk);
            tracker.check_value(rsp_ch.random_value);
            beats++;
        end
    end

    // watchdog on cycles with no beat on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_MAX)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without a beat", STALL_MAX);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_DRAW;
        req_ch.seconds      = '0;
        req_ch.microseconds = '0;
        req_ch.ticks        = '0;
        req_steady          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both indices equal after reset
        repeat (3) send_draw();
        send_request(OP_RESEED, 32'd0, 20'd0, 32'd0);
        repeat (2) send_draw();
        send_request(OP_RESEED, 32'hFFFF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF);
        repeat (2) send_draw();
        send_request(OP_RESEED, 32'd0, 20'd999_999, 32'd0);
        send_draw();
        send_request(OP_RESEED, 32'd1, 20'd0, 32'hFFFF_FFFF);
        send_request(OP_RESEED, 32'h8000_0000, 20'h8_0000, 32'h0000_0001);
        repeat (6) send_draw();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 50 == 0)
                req_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0)
                send_random_reseed();
            else
                send_draw();
        end
        req_ch.valid <= 1'b0;

        while (tracker.expected_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        tracker.check_drained();

        $display("covered %0d draws and %0d reseeds, %0d random values checked",
                 tracker.draws, tracker.reseeds, tracker.values_seen);
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- lagged_fibonacci_random.f -----
hw/rtl/lfr_pkg.sv
hw/rtl/lfr_channels.sv
hw/rtl/lagged_fibonacci_random.sv
hw/rtl/lfr_checker.sv
tb/lagged_fibonacci_random_tb.sv
